/* rtl/wlrgb_pkg.sv */
package wlrgb_pkg;

  localparam int WL_W       = 14;
  localparam int INT_W      = 9;
  localparam int OUT_BITS   = 8;
  localparam int Q_FRAC     = 16;
  localparam int Q_W        = Q_FRAC + 1;
  localparam int F_W        = Q_W + 1;
  localparam int NUM_LINES  = 7;
  localparam int NOTCH_SPAN = 55;
  localparam int NOTCH_CODE_W = 6;
  localparam int RAMP_NUM_W = 14;
  localparam int RCP_W      = 36;
  localparam int RCP_SHIFT  = 28;
  localparam int RCP_EXP    = RCP_SHIFT + Q_FRAC;
  localparam int CFG_INDEX_W = 2;

  localparam logic [Q_W-1:0]      ONE_Q16   = Q_W'(1 << Q_FRAC);
  localparam logic [INT_W-1:0]    INTEN_ONE = INT_W'(256);
  localparam logic [OUT_BITS-1:0] FULL      = OUT_BITS'((1 << OUT_BITS) - 1);

  localparam logic [CFG_INDEX_W-1:0] CFG_NOTCH_ENABLE = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_INVERT_MODE  = CFG_INDEX_W'(1);

  // band edges in 1/16 nm
  localparam logic [WL_W-1:0] W_380 = WL_W'(6080);
  localparam logic [WL_W-1:0] W_420 = WL_W'(6720);
  localparam logic [WL_W-1:0] W_440 = WL_W'(7040);
  localparam logic [WL_W-1:0] W_490 = WL_W'(7840);
  localparam logic [WL_W-1:0] W_510 = WL_W'(8160);
  localparam logic [WL_W-1:0] W_580 = WL_W'(9280);
  localparam logic [WL_W-1:0] W_645 = WL_W'(10320);
  localparam logic [WL_W-1:0] W_701 = WL_W'(11216);
  localparam logic [WL_W-1:0] W_781 = WL_W'(12496);

  // falloff numerators: 7w - 40640 below, 91200 - 7w above
  localparam logic [WL_W+2:0] FALL_LO_OFS = (WL_W+3)'(40640);
  localparam logic [WL_W+2:0] FALL_HI_OFS = (WL_W+3)'(91200);

  // ceil(2^44 / den): floor(num * rcp >> 28) == floor(num * 65536 / den)
  localparam logic [RCP_W-1:0] RCP_960   = RCP_W'(((64'd1 << RCP_EXP) + 64'd959) / 64'd960);
  localparam logic [RCP_W-1:0] RCP_1120  = RCP_W'(((64'd1 << RCP_EXP) + 64'd1119) / 64'd1120);
  localparam logic [RCP_W-1:0] RCP_800   = RCP_W'(((64'd1 << RCP_EXP) + 64'd799) / 64'd800);
  localparam logic [RCP_W-1:0] RCP_1040  = RCP_W'(((64'd1 << RCP_EXP) + 64'd1039) / 64'd1040);
  localparam logic [RCP_W-1:0] RCP_320   = RCP_W'(((64'd1 << RCP_EXP) + 64'd319) / 64'd320);
  localparam logic [RCP_W-1:0] RCP_6400  = RCP_W'(((64'd1 << RCP_EXP) + 64'd6399) / 64'd6400);
  localparam logic [RCP_W-1:0] RCP_12800 = RCP_W'(((64'd1 << RCP_EXP) + 64'd12799) / 64'd12800);

  localparam logic [WL_W-1:0] BALMER_LINE [NUM_LINES] = '{
    14'd10504, 14'd7780, 14'd6947, 14'd6565, 14'd6354, 14'd6224, 14'd6138
  };

  localparam logic [Q_W-1:0] NOTCH_TABLE [NOTCH_SPAN] = '{
    17'd0,     17'd256,   17'd1016,  17'd2264,  17'd3971,  17'd6097,  17'd8597,  17'd11417,
    17'd14497, 17'd17776, 17'd21192, 17'd24685, 17'd28195, 17'd31669, 17'd35059, 17'd38323,
    17'd41427, 17'd44343, 17'd47051, 17'd49538, 17'd51799, 17'd53832, 17'd55642, 17'd57237,
    17'd58629, 17'd59832, 17'd60862, 17'd61736, 17'd62471, 17'd63083, 17'd63588, 17'd64001,
    17'd64336, 17'd64605, 17'd64819, 17'd64989, 17'd65121, 17'd65224, 17'd65303, 17'd65364,
    17'd65409, 17'd65444, 17'd65469, 17'd65488, 17'd65502, 17'd65512, 17'd65519, 17'd65524,
    17'd65528, 17'd65530, 17'd65532, 17'd65533, 17'd65534, 17'd65535, 17'd65535
  };

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_ONE,
    MODE_RAMP
  } shape_mode_t;

  typedef struct packed {
    shape_mode_t           mode;
    logic                  sel;
    logic [RAMP_NUM_W-1:0] num;
  } ramp_req_t;

  typedef struct packed {
    logic [WL_W-1:0]  wavelength;
    logic [INT_W-1:0] intensity;
  } wlrgb_in_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] red;
    logic [OUT_BITS-1:0] green;
    logic [OUT_BITS-1:0] blue;
  } wlrgb_out_t;

  function automatic logic [Q_W-1:0] notch_lut(input logic [NOTCH_CODE_W-1:0] code);
    logic [Q_W-1:0] val;
    if (code < NOTCH_CODE_W'(NOTCH_SPAN)) begin
      val = NOTCH_TABLE[code];
    end else begin
      val = ONE_Q16;
    end
    return val;
  endfunction

endpackage

/* rtl/wlrgb_ramp.sv */
module wlrgb_ramp #(
  parameter logic [wlrgb_pkg::RCP_W-1:0] RCP0 = wlrgb_pkg::RCP_960,
  parameter logic [wlrgb_pkg::RCP_W-1:0] RCP1 = wlrgb_pkg::RCP_960
) (
  input  logic                        clk,
  input  wlrgb_pkg::ramp_req_t        req,
  output logic [wlrgb_pkg::Q_W-1:0]   q_r
);

  localparam int PROD_W = wlrgb_pkg::RAMP_NUM_W + wlrgb_pkg::RCP_W;

  logic [wlrgb_pkg::RCP_W-1:0] rcp;
  logic [PROD_W-1:0]           prod;
  logic [wlrgb_pkg::Q_W-1:0]   q_nxt;

  always_comb begin
    rcp  = req.sel ? RCP1 : RCP0;
    prod = PROD_W'(req.num) * PROD_W'(rcp);
    case (req.mode)
      wlrgb_pkg::MODE_ONE:  q_nxt = wlrgb_pkg::ONE_Q16;
      wlrgb_pkg::MODE_RAMP: q_nxt = prod[wlrgb_pkg::RCP_SHIFT +: wlrgb_pkg::Q_W];
      default:              q_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

/* rtl/wlrgb_chan.sv */
module wlrgb_chan (
  input  logic                           clk,
  input  logic [wlrgb_pkg::Q_W-1:0]      shp,
  input  logic [wlrgb_pkg::F_W-1:0]      fac,
  input  logic                           invert,
  output logic [wlrgb_pkg::OUT_BITS-1:0] out_r
);

  localparam int PROD_W  = wlrgb_pkg::Q_W + wlrgb_pkg::F_W;
  localparam int SCALE_W = wlrgb_pkg::Q_W + wlrgb_pkg::OUT_BITS;

  logic [PROD_W-1:0]                 prod;
  logic [PROD_W-wlrgb_pkg::Q_FRAC-1:0] v;
  logic [wlrgb_pkg::Q_W-1:0]         v_nxt;
  logic [wlrgb_pkg::Q_W-1:0]         v_r;
  logic                              inv_r;
  logic [SCALE_W-1:0]                scaled;
  logic [wlrgb_pkg::OUT_BITS-1:0]    res;
  logic [wlrgb_pkg::OUT_BITS-1:0]    out_nxt;

  always_comb begin
    prod = PROD_W'(shp) * PROD_W'(fac);
    v    = prod[PROD_W-1:wlrgb_pkg::Q_FRAC];
    if (v > (PROD_W-wlrgb_pkg::Q_FRAC)'(wlrgb_pkg::ONE_Q16)) begin
      v_nxt = wlrgb_pkg::ONE_Q16;
    end else begin
      v_nxt = v[wlrgb_pkg::Q_W-1:0];
    end
  end

  // v * full as (v << bits) - v
  always_comb begin
    scaled  = {v_r, wlrgb_pkg::OUT_BITS'(0)} - SCALE_W'(v_r);
    res     = scaled[wlrgb_pkg::Q_FRAC +: wlrgb_pkg::OUT_BITS];
    out_nxt = inv_r ? (wlrgb_pkg::FULL - res) : res;
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    inv_r <= invert;
    out_r <= out_nxt;
  end

endmodule

/* rtl/wavelength_to_rgb.sv */
// wavelength to rgb color lookup, fully pipelined
//
// input: a transfer happens on a rising edge with start high and busy low.
// busy is always low, so a new wavelength/intensity pair can be given on
// every cycle. results leave in the order the items came in.
// output: out_valid is high for exactly one cycle per item with red, green
// and blue on out_data; the receiver has no way to hold a result back.
// configuration: cfg_ready is always high; cfg_index 0 is notch_enable and
// 1 is invert_mode, bit cfg_data is written. other indexes are dropped.
// change registers only while no item is in flight.
// throughput: one item per cycle, set by the registered stages: band
// decode, ramp reciprocal multiply, falloff square, one stage per balmer
// notch, intensity scale, and two stages per output channel.
// reset: rst_n synchronous, active low; clears the pipeline valid bits and
// both configuration registers. nothing is in flight after reset.
module wavelength_to_rgb (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  wlrgb_pkg::wlrgb_in_t                  in_data,
  output logic                                  out_valid,
  output wlrgb_pkg::wlrgb_out_t                 out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wlrgb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic                                  cfg_data
);

  localparam int Q_W  = wlrgb_pkg::Q_W;
  localparam int F_W  = wlrgb_pkg::F_W;
  localparam int NL   = wlrgb_pkg::NUM_LINES;
  localparam int WL_W = wlrgb_pkg::WL_W;
  localparam int CW   = wlrgb_pkg::NOTCH_CODE_W;

  typedef struct packed {
    logic [Q_W-1:0]             shp_r;
    logic [Q_W-1:0]             shp_g;
    logic [Q_W-1:0]             shp_b;
    logic [wlrgb_pkg::INT_W-1:0] inten;
    logic                       invert;
    logic [NL-1:0][Q_W-1:0]     notch;
    logic [Q_W-1:0]             fx;
  } mid_t;

  logic notch_en_r;
  logic invert_r;
  logic in_fire;

  logic [WL_W-1:0]   w;
  logic [WL_W+2:0]   w7;
  logic [WL_W-1:0]   ad [NL];

  wlrgb_pkg::ramp_req_t r_req_nxt, g_req_nxt, b_req_nxt, f_req_nxt;
  wlrgb_pkg::ramp_req_t r_req_r, g_req_r, b_req_r, f_req_r;
  logic [CW-1:0]        code_nxt [NL];
  logic [CW-1:0]        code_r [NL];
  logic [wlrgb_pkg::INT_W-1:0] inten_nxt;
  logic [wlrgb_pkg::INT_W-1:0] inten1_r, inten2_r;
  logic                 inv1_r, inv2_r;
  logic                 v1_r, v2_r;

  logic [Q_W-1:0]       shp_r_q, shp_g_q, shp_b_q, fall_q;
  logic [NL-1:0][Q_W-1:0] notch2_r;

  logic [2*Q_W-1:0]     sq;
  mid_t                 pipe_r [NL+1];
  logic                 vp_r [NL+1];
  logic [2*Q_W-1:0]     nprod [NL];

  localparam int IP_W = Q_W + wlrgb_pkg::INT_W;
  logic [IP_W-1:0]      ip;
  logic [F_W-1:0]       f11_r;
  logic [Q_W-1:0]       s11_r_r, s11_g_r, s11_b_r;
  logic                 inv11_r;
  logic                 v11_r, v12_r, out_valid_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_fire   = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      notch_en_r <= 1'b0;
      invert_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wlrgb_pkg::CFG_NOTCH_ENABLE: notch_en_r <= cfg_data;
        wlrgb_pkg::CFG_INVERT_MODE:  invert_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: band decode, ramp numerators, notch distances
  assign w  = in_data.wavelength;
  assign w7 = {w, 3'b000} - (WL_W+3)'(w);

  always_comb begin
    r_req_nxt.mode = wlrgb_pkg::MODE_ZERO;
    r_req_nxt.sel  = 1'b0;
    r_req_nxt.num  = '0;
    if (w inside {[wlrgb_pkg::W_380 : wlrgb_pkg::W_440 - 14'd1]}) begin
      r_req_nxt.mode = wlrgb_pkg::MODE_RAMP;
      r_req_nxt.num  = wlrgb_pkg::W_440 - w;
    end else if (w inside {[wlrgb_pkg::W_510 : wlrgb_pkg::W_580 - 14'd1]}) begin
      r_req_nxt.mode = wlrgb_pkg::MODE_RAMP;
      r_req_nxt.sel  = 1'b1;
      r_req_nxt.num  = w - wlrgb_pkg::W_510;
    end else if (w inside {[wlrgb_pkg::W_580 : wlrgb_pkg::W_781 - 14'd1]}) begin
      r_req_nxt.mode = wlrgb_pkg::MODE_ONE;
    end

    g_req_nxt.mode = wlrgb_pkg::MODE_ZERO;
    g_req_nxt.sel  = 1'b0;
    g_req_nxt.num  = '0;
    if (w inside {[wlrgb_pkg::W_440 : wlrgb_pkg::W_490 - 14'd1]}) begin
      g_req_nxt.mode = wlrgb_pkg::MODE_RAMP;
      g_req_nxt.num  = w - wlrgb_pkg::W_440;
    end else if (w inside {[wlrgb_pkg::W_490 : wlrgb_pkg::W_580 - 14'd1]}) begin
      g_req_nxt.mode = wlrgb_pkg::MODE_ONE;
    end else if (w inside {[wlrgb_pkg::W_580 : wlrgb_pkg::W_645 - 14'd1]}) begin
      g_req_nxt.mode = wlrgb_pkg::MODE_RAMP;
      g_req_nxt.sel  = 1'b1;
      g_req_nxt.num  = wlrgb_pkg::W_645 - w;
    end

    b_req_nxt.mode = wlrgb_pkg::MODE_ZERO;
    b_req_nxt.sel  = 1'b0;
    b_req_nxt.num  = '0;
    if (w inside {[wlrgb_pkg::W_380 : wlrgb_pkg::W_490 - 14'd1]}) begin
      b_req_nxt.mode = wlrgb_pkg::MODE_ONE;
    end else if (w inside {[wlrgb_pkg::W_490 : wlrgb_pkg::W_510 - 14'd1]}) begin
      b_req_nxt.mode = wlrgb_pkg::MODE_RAMP;
      b_req_nxt.num  = wlrgb_pkg::W_510 - w;
    end

    f_req_nxt.mode = wlrgb_pkg::MODE_ZERO;
    f_req_nxt.sel  = 1'b0;
    f_req_nxt.num  = '0;
    if (w inside {[wlrgb_pkg::W_380 : wlrgb_pkg::W_420 - 14'd1]}) begin
      f_req_nxt.mode = wlrgb_pkg::MODE_RAMP;
      f_req_nxt.num  = WL_W'(w7 - wlrgb_pkg::FALL_LO_OFS);
    end else if (w inside {[wlrgb_pkg::W_420 : wlrgb_pkg::W_701 - 14'd1]}) begin
      f_req_nxt.mode = wlrgb_pkg::MODE_ONE;
    end else if (w inside {[wlrgb_pkg::W_701 : wlrgb_pkg::W_781 - 14'd1]}) begin
      f_req_nxt.mode = wlrgb_pkg::MODE_RAMP;
      f_req_nxt.sel  = 1'b1;
      f_req_nxt.num  = WL_W'(wlrgb_pkg::FALL_HI_OFS - w7);
    end

    for (int i = 0; i < NL; i++) begin
      if (w >= wlrgb_pkg::BALMER_LINE[i]) begin
        ad[i] = w - wlrgb_pkg::BALMER_LINE[i];
      end else begin
        ad[i] = wlrgb_pkg::BALMER_LINE[i] - w;
      end
      // out-of-span code reads as 1.0
      if (notch_en_r && !invert_r && (ad[i] < WL_W'(wlrgb_pkg::NOTCH_SPAN))) begin
        code_nxt[i] = ad[i][CW-1:0];
      end else begin
        code_nxt[i] = CW'(wlrgb_pkg::NOTCH_SPAN);
      end
    end

    inten_nxt = invert_r ? wlrgb_pkg::INTEN_ONE : in_data.intensity;
  end

  always_ff @(posedge clk) begin
    r_req_r  <= r_req_nxt;
    g_req_r  <= g_req_nxt;
    b_req_r  <= b_req_nxt;
    f_req_r  <= f_req_nxt;
    code_r   <= code_nxt;
    inten1_r <= inten_nxt;
    inv1_r   <= invert_r;
  end

  // stage 2: ramps by reciprocal multiply, notch table
  wlrgb_ramp #(.RCP0(wlrgb_pkg::RCP_960), .RCP1(wlrgb_pkg::RCP_1120)) u_ramp_r (
    .clk (clk), .req (r_req_r), .q_r (shp_r_q)
  );
  wlrgb_ramp #(.RCP0(wlrgb_pkg::RCP_800), .RCP1(wlrgb_pkg::RCP_1040)) u_ramp_g (
    .clk (clk), .req (g_req_r), .q_r (shp_g_q)
  );
  wlrgb_ramp #(.RCP0(wlrgb_pkg::RCP_320), .RCP1(wlrgb_pkg::RCP_320)) u_ramp_b (
    .clk (clk), .req (b_req_r), .q_r (shp_b_q)
  );
  wlrgb_ramp #(.RCP0(wlrgb_pkg::RCP_6400), .RCP1(wlrgb_pkg::RCP_12800)) u_ramp_f (
    .clk (clk), .req (f_req_r), .q_r (fall_q)
  );

  always_ff @(posedge clk) begin
    for (int i = 0; i < NL; i++) begin
      notch2_r[i] <= wlrgb_pkg::notch_lut(code_r[i]);
    end
    inten2_r <= inten1_r;
    inv2_r   <= inv1_r;
  end

  // stage 3: square the falloff
  assign sq = (2*Q_W)'(fall_q) * (2*Q_W)'(fall_q);

  always_ff @(posedge clk) begin
    pipe_r[0].shp_r  <= shp_r_q;
    pipe_r[0].shp_g  <= shp_g_q;
    pipe_r[0].shp_b  <= shp_b_q;
    pipe_r[0].inten  <= inten2_r;
    pipe_r[0].invert <= inv2_r;
    pipe_r[0].notch  <= notch2_r;
    pipe_r[0].fx     <= sq[wlrgb_pkg::Q_FRAC +: Q_W];
  end

  // one stage per balmer notch
  for (genvar g = 0; g < NL; g++) begin : g_notch
    mid_t stage_nxt;

    assign nprod[g] = (2*Q_W)'(pipe_r[g].fx) * (2*Q_W)'(pipe_r[g].notch[g]);

    always_comb begin
      stage_nxt    = pipe_r[g];
      stage_nxt.fx = nprod[g][wlrgb_pkg::Q_FRAC +: Q_W];
    end

    always_ff @(posedge clk) begin
      pipe_r[g+1] <= stage_nxt;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vp_r[g+1] <= 1'b0;
      end else begin
        vp_r[g+1] <= vp_r[g];
      end
    end
  end

  // intensity scale, 256 is unity
  assign ip = IP_W'(pipe_r[NL].fx) * IP_W'(pipe_r[NL].inten);

  always_ff @(posedge clk) begin
    f11_r   <= ip[8 +: F_W];
    s11_r_r <= pipe_r[NL].shp_r;
    s11_g_r <= pipe_r[NL].shp_g;
    s11_b_r <= pipe_r[NL].shp_b;
    inv11_r <= pipe_r[NL].invert;
  end

  wlrgb_chan u_chan_r (
    .clk (clk), .shp (s11_r_r), .fac (f11_r), .invert (inv11_r), .out_r (out_data.red)
  );
  wlrgb_chan u_chan_g (
    .clk (clk), .shp (s11_g_r), .fac (f11_r), .invert (inv11_r), .out_r (out_data.green)
  );
  wlrgb_chan u_chan_b (
    .clk (clk), .shp (s11_b_r), .fac (f11_r), .invert (inv11_r), .out_r (out_data.blue)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      vp_r[0]     <= 1'b0;
      v11_r       <= 1'b0;
      v12_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= in_fire;
      v2_r        <= v1_r;
      vp_r[0]     <= v2_r;
      v11_r       <= vp_r[NL];
      v12_r       <= v11_r;
      out_valid_r <= v12_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
